### hw/rtl/two_class_preemptive_scheduler_top_defines.svh
// Assertion macros for the two-class preemptive scheduler.
`ifndef TWO_CLASS_PREEMPTIVE_SCHEDULER_TOP_DEFINES_SVH
`define TWO_CLASS_PREEMPTIVE_SCHEDULER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define TCPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
`else
`define TCPS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define TCPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/tcps_pkg.sv
// Shared constants and types of the two-class preemptive scheduler.
package tcps_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_BITS   = 32;
	localparam int SVC_W       = 32;
	localparam int RESP_W      = 32;
	localparam int COUNT_W     = 5;
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 48;

	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_ARRIVAL = 1'b1;

	typedef struct packed {
		logic [SVC_W-1:0]     svc;
		logic [TIME_BITS-1:0] arr;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

endpackage

### hw/rtl/tcps_cell.sv
// One queue cell: holds a job entry, takes its neighbour's entry on a pop.
module tcps_cell (
	input  logic            clk,
	input  logic            load,
	input  logic            shift,
	input  tcps_pkg::entry_t new_entry,
	input  tcps_pkg::entry_t nbr_entry,
	output tcps_pkg::entry_t entry
);

	tcps_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= nbr_entry;
		end else if (load) begin
			entry_q <= new_entry;
		end
	end

	assign entry = entry_q;

endmodule

### hw/rtl/tcps_queue.sv
// Job FIFO built as a row of cells with the head fixed at cell zero.
module tcps_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcps_pkg::queue_ctl_t        ctl,
	input  tcps_pkg::entry_t            new_entry,
	output tcps_pkg::entry_t            head,
	output tcps_pkg::entry_t            second,
	output logic [tcps_pkg::FILL_W-1:0] fill,
	output logic                        full
);

	logic [tcps_pkg::FILL_W-1:0] fill_q;
	tcps_pkg::entry_t            cells [tcps_pkg::QUEUE_DEPTH];

	for (genvar i = 0; i < tcps_pkg::QUEUE_DEPTH; i++) begin : g_cell
		tcps_pkg::entry_t nbr;
		logic             load;

		// last cell has no neighbour: hold on a pop, its content is stale anyway
		if (i == tcps_pkg::QUEUE_DEPTH - 1) begin : g_last
			assign nbr = cells[i];
		end else begin : g_mid
			assign nbr = cells[i+1];
		end

		assign load = ctl.push && (fill_q == tcps_pkg::FILL_W'(i));

		tcps_cell u_cell (
			.clk       (clk),
			.load      (load),
			.shift     (ctl.pop),
			.new_entry (new_entry),
			.nbr_entry (nbr),
			.entry     (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.push) begin
			fill_q <= fill_q + tcps_pkg::FILL_W'(1);
		end else if (ctl.pop) begin
			fill_q <= fill_q - tcps_pkg::FILL_W'(1);
		end
	end

	assign head   = cells[0];
	assign second = cells[1];
	assign fill   = fill_q;
	assign full   = (fill_q == tcps_pkg::FILL_W'(tcps_pkg::QUEUE_DEPTH));

endmodule

### hw/rtl/two_class_preemptive_scheduler_top.sv
// Top level of the two-class preemptive scheduler: service control and stream ports.
//
//  channel | dir | handshake        | payload
//  s       | in  | s_tvalid/tready  | tuser command, tdata high_priority, service_time
//  m       | out | m_tvalid/tready  | tdata completed ... dropped
//
// One item per cycle: each transfer updates the queues, the clock and the
// countdown in the cycle it is taken, and its result sits in the output
// register in the next cycle. The input is stalled only while that register
// holds a result that m_tready does not take. arst_n clears the clock, the
// countdown, the fill counts and the service flags; queue cells are not reset.
`include "two_class_preemptive_scheduler_top_defines.svh"

module two_class_preemptive_scheduler_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [0] high_priority, [32:1] service_time, [39:33] zero
	input  logic [tcps_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] command
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] completed, [1] completed_high, [33:2] response_time,
	// [38:34] high_count, [43:39] low_count, [44] dropped, [47:45] zero
	output logic [tcps_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int FW = tcps_pkg::FILL_W;
	localparam int SW = tcps_pkg::SVC_W;
	localparam int TW = tcps_pkg::TIME_BITS;

	logic [TW-1:0] time_q;
	logic [SW-1:0] remaining_q;
	logic          serving_high_q;
	logic          serving_low_q;
	logic          out_valid_q;
	logic [tcps_pkg::OUT_DATA_W-1:0] out_data_q;

	tcps_pkg::entry_t     h_head, h_second, l_head, l_second, new_entry;
	tcps_pkg::queue_ctl_t h_ctl, l_ctl;
	logic [FW-1:0]        h_fill, l_fill, h_fill_n, l_fill_n;
	logic                 h_full, l_full;

	logic          accept, is_arr, hp, tick, busy, finish, drop;
	logic [SW-1:0] svc_in, h_head_svc_n, l_head_svc_n, rem_n;
	logic [TW-1:0] time_plus, time_n, done_arr;
	logic [tcps_pkg::RESP_W-1:0] resp;
	logic          sh_n, sl_n;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_arr   = (s_tuser == tcps_pkg::CMD_ARRIVAL);
	assign hp       = s_tdata[0];
	assign svc_in   = s_tdata[SW:1];
	assign tick     = accept && (s_tuser == tcps_pkg::CMD_TICK);
	assign busy     = serving_high_q || serving_low_q;
	assign finish   = tick && busy && (remaining_q <= SW'(1));
	assign drop     = is_arr && (hp ? h_full : l_full);

	assign h_ctl.push = accept && is_arr && hp && !h_full;
	assign l_ctl.push = accept && is_arr && !hp && !l_full;
	assign h_ctl.pop  = finish && serving_high_q;
	assign l_ctl.pop  = finish && serving_low_q;

	assign new_entry.svc = svc_in;
	assign new_entry.arr = time_q;

	tcps_queue u_high (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (h_ctl),
		.new_entry (new_entry),
		.head      (h_head),
		.second    (h_second),
		.fill      (h_fill),
		.full      (h_full)
	);

	tcps_queue u_low (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (l_ctl),
		.new_entry (new_entry),
		.head      (l_head),
		.second    (l_second),
		.fill      (l_fill),
		.full      (l_full)
	);

	assign time_plus = time_q + TW'(1);
	assign time_n    = tick ? time_plus : time_q;
	assign done_arr  = serving_high_q ? h_head.arr : l_head.arr;
	assign resp      = finish ? tcps_pkg::RESP_W'(time_plus - done_arr) : '0;

	assign h_fill_n = h_fill + FW'(h_ctl.push) - FW'(h_ctl.pop);
	assign l_fill_n = l_fill + FW'(l_ctl.push) - FW'(l_ctl.pop);

	// head after this transfer: second cell on a pop, the new job into an empty queue
	assign h_head_svc_n = h_ctl.pop ? h_second.svc : ((h_fill == '0) ? svc_in : h_head.svc);
	assign l_head_svc_n = l_ctl.pop ? l_second.svc : ((l_fill == '0) ? svc_in : l_head.svc);

	always_comb begin
		sh_n  = serving_high_q;
		sl_n  = serving_low_q;
		rem_n = remaining_q;
		if (tick && busy) begin
			if (finish) begin
				sh_n  = 1'b0;
				sl_n  = 1'b0;
				rem_n = '0;
			end else begin
				rem_n = remaining_q - SW'(1);
			end
		end
		// preempt a low job; it restarts in full later
		if (h_ctl.push && serving_low_q) begin
			sl_n  = 1'b0;
			rem_n = '0;
		end
		if (!sh_n && !sl_n) begin
			if (h_fill_n != '0) begin
				sh_n  = 1'b1;
				rem_n = h_head_svc_n;
			end else if (l_fill_n != '0) begin
				sl_n  = 1'b1;
				rem_n = l_head_svc_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q         <= '0;
			remaining_q    <= '0;
			serving_high_q <= 1'b0;
			serving_low_q  <= 1'b0;
		end else if (accept) begin
			time_q         <= time_n;
			remaining_q    <= rem_n;
			serving_high_q <= sh_n;
			serving_low_q  <= sl_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {3'b000, drop && accept,
				tcps_pkg::COUNT_W'(l_fill_n), tcps_pkg::COUNT_W'(h_fill_n),
				resp, finish && serving_high_q, finish};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`TCPS_ASSERT_NEVER(a_one_class_served, clk, arst_n, serving_high_q && serving_low_q, "both classes in service")
	`TCPS_ASSERT_IMPLY(a_high_has_job, clk, arst_n, serving_high_q, h_fill != '0, "high job served from empty queue")
	`TCPS_ASSERT_IMPLY(a_low_only_alone, clk, arst_n, serving_low_q, (l_fill != '0) && (h_fill == '0), "low job served while high jobs wait")

endmodule

### test/two_class_preemptive_scheduler_top_test.sv
// Self-checking stream testbench for the two-class preemptive scheduler top level.
module two_class_preemptive_scheduler_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcps_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int OPENING_ROWS  = 17;
	localparam int HEAD_W        = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic                done;
		logic                done_high;
		logic [RESP_W-1:0]   resp;
		logic [COUNT_W-1:0]  high_count;
		logic [COUNT_W-1:0]  low_count;
		logic                dropped;
	} sched_result_t;

	typedef struct packed {
		logic              cmd;
		logic              high;
		logic [SVC_W-1:0]  svc;
		logic [7:0]        reps;
		logic              fixed;
		sched_result_t     want;
	} opening_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;

	// Scheduler mirror: index 1 is the high class, index 0 the low class
	logic [SVC_W-1:0]      job_service [2][QUEUE_DEPTH];
	logic [TIME_BITS-1:0]  job_arrival [2][QUEUE_DEPTH];
	logic [HEAD_W-1:0]     queue_head [2];
	logic [FILL_W-1:0]     queue_fill [2];
	logic [TIME_BITS-1:0]  sched_clock;
	logic [SVC_W-1:0]      countdown;
	logic                  busy_high;
	logic                  busy_low;

	sched_result_t  pending_outcomes [$];
	opening_row_t   opening_script [OPENING_ROWS];
	int unsigned    mismatches;
	int unsigned    cycles;
	bit             no_idle;

	two_class_preemptive_scheduler_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic sched_result_t outcome(int unsigned done, int unsigned done_high,
			int unsigned resp, int unsigned hcount, int unsigned lcount,
			int unsigned dropped);
		sched_result_t r;
		r.done       = 1'(done);
		r.done_high  = 1'(done_high);
		r.resp       = RESP_W'(resp);
		r.high_count = COUNT_W'(hcount);
		r.low_count  = COUNT_W'(lcount);
		r.dropped    = 1'(dropped);
		return r;
	endfunction

	function automatic void clear_schedule();
		sched_clock   = '0;
		countdown     = '0;
		busy_high     = 1'b0;
		busy_low      = 1'b0;
		queue_head[0] = '0;
		queue_head[1] = '0;
		queue_fill[0] = '0;
		queue_fill[1] = '0;
	endfunction

	// Advance the mirror by one transfer and return the result it owes
	function automatic sched_result_t schedule_step(logic cmd, logic high, logic [SVC_W-1:0] svc);
		sched_result_t      r;
		logic               c;
		logic [HEAD_W-1:0]  slot;
		r = '0;
		if (cmd == CMD_ARRIVAL) begin
			c = high;
			if (queue_fill[c] == QUEUE_DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				slot = queue_head[c] + queue_fill[c][HEAD_W-1:0];
				job_service[c][slot] = svc;
				job_arrival[c][slot] = sched_clock;
				queue_fill[c] = queue_fill[c] + 1'b1;
				// a high arrival throws the low job back to the head of its queue
				if (high && busy_low) begin
					busy_low  = 1'b0;
					countdown = '0;
				end
			end
		end else begin
			sched_clock = sched_clock + 1'b1;
			if (busy_high || busy_low) begin
				if (countdown <= 1) begin
					c = busy_high;
					r.done      = 1'b1;
					r.done_high = busy_high;
					r.resp      = sched_clock - job_arrival[c][queue_head[c]];
					queue_head[c] = queue_head[c] + 1'b1;
					queue_fill[c] = queue_fill[c] - 1'b1;
					busy_high = 1'b0;
					busy_low  = 1'b0;
					countdown = '0;
				end else begin
					countdown = countdown - 1'b1;
				end
			end
		end
		if (!busy_high && !busy_low) begin
			if (queue_fill[1] != 0) begin
				busy_high = 1'b1;
				countdown = job_service[1][queue_head[1]];
			end else if (queue_fill[0] != 0) begin
				busy_low  = 1'b1;
				countdown = job_service[0][queue_head[0]];
			end
		end
		r.high_count = queue_fill[1];
		r.low_count  = queue_fill[0];
		return r;
	endfunction

	function automatic int idle_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SVC_W-1:0] short_service();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r < 12)
			return $urandom_range(1, 4);
		if (r < 18)
			return $urandom_range(5, 12);
		return $urandom_range(13, 60);
	endfunction

	// Drive one item from the falling edge and hold it until the transfer
	task automatic send_item(logic cmd, logic high, logic [SVC_W-1:0] svc, logic fixed,
			sched_result_t want);
		int             gap;
		sched_result_t  model;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(IN_DATA_W - SVC_W - 1){1'b0}}, svc, high};
		do
			@(posedge clk);
		while (!s_tready);
		model = schedule_step(cmd, high, svc);
		pending_outcomes.push_back(fixed ? want : model);
		@(negedge clk);
	endtask

	task automatic send_noise_tick();
		send_item(CMD_TICK, logic'($urandom_range(0, 1)), $urandom, 1'b0, '0);
	endtask

	// Result checker
	always @(posedge clk) begin
		sched_result_t got;
		sched_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.done       = m_tdata[0];
			got.done_high  = m_tdata[1];
			got.resp       = m_tdata[33:2];
			got.high_count = m_tdata[38:34];
			got.low_count  = m_tdata[43:39];
			got.dropped    = m_tdata[44];
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing outstanding: done=%0d", $realtime,
						got.done);
			end else begin
				want = pending_outcomes.pop_front();
				if (got.done !== want.done || got.done_high !== want.done_high ||
						got.resp !== want.resp || got.high_count !== want.high_count ||
						got.low_count !== want.low_count || got.dropped !== want.dropped) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: expected done=%0d high=%0d resp=%0d hq=%0d lq=%0d drop=%0d",
							$realtime, want.done, want.done_high, want.resp,
							want.high_count, want.low_count, want.dropped);
						$display("%0t: actual   done=%0d high=%0d resp=%0d hq=%0d lq=%0d drop=%0d",
							$realtime, got.done, got.done_high, got.resp,
							got.high_count, got.low_count, got.dropped);
					end
				end
			end
		end
	end

	// Receiver back-pressure
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			gap = idle_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("two_class_preemptive_scheduler_top_test: errors");
			$finish;
		end
	end

	initial begin
		int    sent;
		int    phase_len;
		int    arrival_pct;
		int    c;
		int    k;
		logic  cmd;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = CMD_TICK;
		mismatches = 0;
		cycles     = 0;
		no_idle    = 1'b0;
		clear_schedule();

		opening_script[0]  = '{CMD_TICK,    1'b0, 32'd0, 8'd1, 1'b1, outcome(0, 0, 0, 0, 0, 0)};
		opening_script[1]  = '{CMD_ARRIVAL, 1'b1, 32'd1, 8'd1, 1'b1, outcome(0, 0, 0, 1, 0, 0)};
		opening_script[2]  = '{CMD_TICK,    1'b0, 32'd0, 8'd1, 1'b1, outcome(1, 1, 1, 0, 0, 0)};
		// zero service time lasts one tick
		opening_script[3]  = '{CMD_ARRIVAL, 1'b0, 32'd0, 8'd1, 1'b1, outcome(0, 0, 0, 0, 1, 0)};
		opening_script[4]  = '{CMD_TICK,    1'b0, 32'd0, 8'd1, 1'b1, outcome(1, 0, 1, 0, 0, 0)};
		opening_script[5]  = '{CMD_ARRIVAL, 1'b0, 32'd3, 8'd1, 1'b0, '0};
		opening_script[6]  = '{CMD_TICK,    1'b0, 32'd0, 8'd1, 1'b0, '0};
		// preempt the low job, then queue behind a high job
		opening_script[7]  = '{CMD_ARRIVAL, 1'b1, 32'd2, 8'd1, 1'b0, '0};
		opening_script[8]  = '{CMD_ARRIVAL, 1'b1, 32'd1, 8'd1, 1'b0, '0};
		opening_script[9]  = '{CMD_TICK,    1'b1, 32'hFFFF_FFFF, 8'd5, 1'b0, '0};
		opening_script[10] = '{CMD_ARRIVAL, 1'b1, 32'd0, 8'd1, 1'b0, '0};
		opening_script[11] = '{CMD_TICK,    1'b0, 32'd0, 8'd2, 1'b0, '0};
		opening_script[12] = '{CMD_ARRIVAL, 1'b0, 32'd1, 8'd1, 1'b0, '0};
		opening_script[13] = '{CMD_ARRIVAL, 1'b1, 32'd4, 8'd1, 1'b0, '0};
		opening_script[14] = '{CMD_TICK,    1'b0, 32'd0, 8'd3, 1'b0, '0};
		opening_script[15] = '{CMD_ARRIVAL, 1'b0, 32'd2, 8'd1, 1'b0, '0};
		opening_script[16] = '{CMD_TICK,    1'b0, 32'd0, 8'd3, 1'b0, '0};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < OPENING_ROWS; i++)
			repeat (opening_script[i].reps)
				send_item(opening_script[i].cmd, opening_script[i].high,
					opening_script[i].svc, opening_script[i].fixed, opening_script[i].want);

		// Random phases: the arrival rate swings so queues both fill and drain
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(20, 80);
			case ($urandom_range(0, 3))
				0: arrival_pct = 5;
				1: arrival_pct = 20;
				2: arrival_pct = 45;
				default: arrival_pct = 70;
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			for (k = 0; k < phase_len; k++) begin
				cmd = ($urandom_range(0, 99) < arrival_pct) ? CMD_ARRIVAL : CMD_TICK;
				if (cmd == CMD_ARRIVAL)
					send_item(CMD_ARRIVAL, logic'($urandom_range(0, 1)), short_service(),
						1'b0, '0);
				else
					send_noise_tick();
			end
			sent += phase_len;
		end
		no_idle = 1'b0;

		// Long jobs last: they would stall the queues for the rest of the run.
		// Overfill each class so the full-queue drop is taken on both.
		for (c = 0; c < 2; c++)
			for (k = 0; k <= QUEUE_DEPTH; k++)
				send_item(CMD_ARRIVAL, logic'(c), (k == 0) ? 32'hFFFF_FFFF : $urandom,
					1'b0, '0);
		repeat (20)
			send_noise_tick();

		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("two_class_preemptive_scheduler_top_test: clean");
		else
			$display("two_class_preemptive_scheduler_top_test: errors");
		$finish;
	end

endmodule
